[src/itfc_pkg.sv]
// Package for the idle-timeout frame checker: item and result types,
// command and register codes, buffer geometry and reset values.
// No dependencies.
`default_nettype none

package itfc_pkg;

    // Receive buffer geometry; the write index saturates at its top slot.
    localparam int BUFFER_DEPTH = 64;
    localparam int COUNT_W      = 6;
    localparam logic [COUNT_W-1:0] MAX_INDEX = COUNT_W'(BUFFER_DEPTH - 1);

    // Bytes 3..8 of a frame carry the three big-endian 16-bit values.
    localparam int FIELD_FIRST     = 3;
    localparam int NUM_FIELD_BYTES = 6;
    localparam int NUM_VALUES      = 3;

    localparam logic [7:0] IDLE_LIMIT_RST  = 8'd5;
    localparam logic [7:0] HEADER_BYTE_RST = 8'h16;
    localparam logic [7:0] TIMER_MAX       = 8'hFF;

    typedef enum logic
    {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic
    {
        REG_IDLE_LIMIT  = 1'b0,
        REG_HEADER_BYTE = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        cmd_t       cmd;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed
    {
        logic               frame_ok;
        logic [COUNT_W-1:0] frame_length;
        logic [15:0]        concentration;
        logic [15:0]        flow;
        logic [15:0]        temperature;
    } result_t;

endpackage : itfc_pkg

`default_nettype wire

[src/itfc_in_stage.sv]
// Input register of the frame checker: holds one accepted transaction.
// Depends on itfc_pkg.
`default_nettype none

module itfc_in_stage
    import itfc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  consume,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new transaction when none is held or the held one leaves this cycle.
    assign in_ready   = !valid_reg || consume;
    assign valid_next = in_valid || (valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule : itfc_in_stage

`default_nettype wire

[src/itfc_frame_core.sv]
// Frame state of the checker: byte index, idle timer, running checksum,
// field bytes, held values and configuration registers. Depends on itfc_pkg.
`default_nettype none

module itfc_frame_core
    import itfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire cfg_reg_t   cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       advance,
    input  wire item_t      item,
    output logic            res_valid,
    output result_t         res
);

    logic [7:0]         idle_limit_reg;
    logic [7:0]         header_byte_reg;
    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic [7:0]         idle_timer_reg;
    logic [7:0]         idle_timer_next;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    logic [7:0]         last_reg;
    logic [7:0]         last_next;
    logic [7:0]         first_reg;
    logic [7:0]         first_next;
    logic [7:0]         field_reg  [NUM_FIELD_BYTES];
    logic [7:0]         field_next [NUM_FIELD_BYTES];
    logic [15:0]        held_reg   [NUM_VALUES];
    logic [15:0]        held_next  [NUM_VALUES];

    logic [7:0]  timer_inc;
    logic        close_frame;
    logic        frame_ok;
    logic [15:0] loaded [NUM_VALUES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg  <= IDLE_LIMIT_RST;
            header_byte_reg <= HEADER_BYTE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IDLE_LIMIT:  idle_limit_reg  <= cfg_data;
                REG_HEADER_BYTE: header_byte_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Tick path: advance the timer only while a frame is open, saturating.
    assign timer_inc = (byte_count_reg != '0 && idle_timer_reg != TIMER_MAX)
                     ? 8'(idle_timer_reg + 8'd1) : idle_timer_reg;
    assign close_frame = (item.cmd == CMD_TICK) && (timer_inc > idle_limit_reg);
    assign frame_ok = (byte_count_reg != '0) && (first_reg == header_byte_reg)
                   && (last_reg == 8'(8'd0 - sum_reg));

    always_comb
    begin
        for (int i = 0; i < NUM_VALUES; i++)
        begin
            loaded[i] = {field_reg[2*i], field_reg[2*i+1]};
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        idle_timer_next = idle_timer_reg;
        sum_next        = sum_reg;
        last_next       = last_reg;
        first_next      = first_reg;
        for (int i = 0; i < NUM_FIELD_BYTES; i++)
        begin
            field_next[i] = field_reg[i];
        end
        for (int i = 0; i < NUM_VALUES; i++)
        begin
            held_next[i] = held_reg[i];
        end

        case (item.cmd)
            CMD_BYTE:
            begin
                if (byte_count_reg == '0)
                begin
                    first_next = item.rx_byte;
                end
                for (int i = 0; i < NUM_FIELD_BYTES; i++)
                begin
                    if (byte_count_reg == COUNT_W'(FIELD_FIRST + i))
                    begin
                        field_next[i] = item.rx_byte;
                    end
                end
                // At the top slot the byte is not stored; index, checksum and last byte hold.
                if (byte_count_reg < MAX_INDEX)
                begin
                    if (byte_count_reg != '0)
                    begin
                        sum_next = 8'(sum_reg + last_reg);
                    end
                    last_next       = item.rx_byte;
                    byte_count_next = COUNT_W'(byte_count_reg + 1'b1);
                end
                idle_timer_next = '0;
            end
            CMD_TICK:
            begin
                idle_timer_next = timer_inc;
                if (close_frame)
                begin
                    if (frame_ok)
                    begin
                        for (int i = 0; i < NUM_VALUES; i++)
                        begin
                            held_next[i] = loaded[i];
                        end
                    end
                    idle_timer_next = '0;
                    byte_count_next = '0;
                    sum_next        = '0;
                    last_next       = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            idle_timer_reg <= '0;
            sum_reg        <= '0;
            last_reg       <= '0;
            first_reg      <= '0;
            for (int i = 0; i < NUM_FIELD_BYTES; i++)
            begin
                field_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            byte_count_reg <= byte_count_next;
            idle_timer_reg <= idle_timer_next;
            sum_reg        <= sum_next;
            last_reg       <= last_next;
            first_reg      <= first_next;
            for (int i = 0; i < NUM_FIELD_BYTES; i++)
            begin
                field_reg[i] <= field_next[i];
            end
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    assign res_valid         = close_frame;
    assign res.frame_ok      = frame_ok;
    assign res.frame_length  = byte_count_reg;
    assign res.concentration = held_next[0];
    assign res.flow          = held_next[1];
    assign res.temperature   = held_next[2];

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_INDEX)
        else $error("byte index ran past the top slot");

    a_timer_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        idle_timer_reg != '0 |-> byte_count_reg != '0)
        else $error("idle timer running with no open frame");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> byte_count_reg == '0 && idle_timer_reg == '0
                                 && sum_reg == '0 && last_reg == '0)
        else $error("frame state not cleared after close");

    a_ok_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.frame_ok |-> res.frame_length != '0)
        else $error("accepted frame with no bytes");

endmodule : itfc_frame_core

`default_nettype wire

[src/itfc_out_stage.sv]
// Result register of the frame checker: holds one result transaction
// until the receiver takes it. Depends on itfc_pkg.
`default_nettype none

module itfc_out_stage
    import itfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res,
    output logic         slot_free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    result_t res_reg;

    // The slot frees in the same cycle the receiver drains it.
    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && slot_free)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule : itfc_out_stage

`default_nettype wire

[src/idle_timeout_frame_checker.sv]
// Top level of the idle-timeout frame checker.
// Depends on itfc_pkg, itfc_in_stage, itfc_frame_core and itfc_out_stage.
//
// Usage:
//   Slave stream (s_*): one transaction per received serial byte or timer
//   tick. s_tuser is the command (0 = byte, 1 = tick), s_tdata the byte.
//   A byte advances the current frame index and clears the idle timer;
//   the index saturates at the top buffer slot. A tick advances the idle
//   timer while a frame is open; when the timer exceeds idle_limit the frame
//   closes and one result transaction goes out on the master stream (m_*).
//   Ticks that close nothing and all bytes produce no output.
//   Result: m_tuser = frame_ok (header and checksum matched), m_tdata carries
//   the frame length and the three held 16-bit values, updated from bytes
//   3..8 when the frame was accepted.
//   Configuration: cfg_we with cfg_index 0 writes idle_limit, 1 writes
//   header_byte; write only while no transaction is in flight.
//   Throughput: one transaction per cycle while m_tready does not stall;
//   every transaction passes an input register and the frame logic, and
//   each result then passes a result register.
//   Stall: while m_tready is low a waiting result holds, one more transaction
//   waits in the input register, and s_tready then drops.
//   Reset (rst_n low): all frame state, held values and both streams clear;
//   idle_limit returns to 5 and header_byte to 0x16.
`default_nettype none

module idle_timeout_frame_checker
    import itfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] cmd
    // Master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [5:0] frame_length, [21:6] concentration,
                                        // [37:22] flow, [53:38] temperature, rest 0
    output logic             m_tuser,   // [0] frame_ok
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    slot_free;
    logic    advance;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.cmd     = cmd_t'(s_tuser);
    assign in_item.rx_byte = s_tdata;

    // Advance the frame state when an item is held and the result slot can
    // take whatever it produces.
    assign advance = item_valid && slot_free;

    itfc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .consume    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    itfc_frame_core u_frame_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_reg_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    itfc_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack result fields, lowest field first, pad to whole bytes.
    assign m_tdata = {2'b00, out_res.temperature, out_res.flow,
                      out_res.concentration, out_res.frame_length};
    assign m_tuser = out_res.frame_ok;

endmodule : idle_timeout_frame_checker

`default_nettype wire

[sim/idle_timeout_frame_checker_tb.sv]
`timescale 1ns / 100ps
// Testbench for idle_timeout_frame_checker: directed frames, then random framed traffic
// under several register settings, checked against an in-bench frame predictor.
// Depends on itfc_pkg and the idle_timeout_frame_checker RTL only.

module idle_timeout_frame_checker_tb;
    import itfc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    // Settling slack after the last expected result has arrived.
    localparam int DRAIN_SLACK = 8;
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam int MAX_PRINTED = 40;

    // ------------------------------------------------------------------
    // Frame scoreboard: mirrors the frame state, holds the expected
    // closing results and compares them with what the block sends out.
    // ------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]         lim;
        logic [7:0]         hdr;
        logic [COUNT_W-1:0] count;
        logic [7:0]         idle_ticks;
        logic [7:0]         run_sum;
        logic [7:0]         tail;
        logic [7:0]         lead;
        logic [7:0]         field_q [NUM_FIELD_BYTES];
        logic [15:0]        held [NUM_VALUES];
        result_t            expected_frames [$];
        int                 mismatches;

        function new();
            lim        = IDLE_LIMIT_RST;
            hdr        = HEADER_BYTE_RST;
            count      = '0;
            idle_ticks = '0;
            run_sum    = '0;
            tail       = '0;
            lead       = '0;
            foreach (field_q[i]) field_q[i] = '0;
            foreach (held[i]) held[i] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [7:0] value);
            if (idx == REG_IDLE_LIMIT)
                lim = value;
            else
                hdr = value;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // Advance the frame state by one accepted transaction; queue the
        // result when a tick closes the frame.
        function void predict_item(item_t it);
            result_t r;
            logic    ok;
            if (it.cmd == CMD_BYTE)
            begin
                if (count == 0)
                    lead = it.rx_byte;
                if (count >= FIELD_FIRST && count < FIELD_FIRST + NUM_FIELD_BYTES)
                    field_q[count - FIELD_FIRST] = it.rx_byte;
                // Top slot reached: the byte is not stored and count, sum and tail hold.
                if (count != MAX_INDEX)
                begin
                    if (count != 0)
                        run_sum = run_sum + tail;
                    tail  = it.rx_byte;
                    count = count + 1'b1;
                end
                idle_ticks = '0;
            end
            else
            begin
                if (count != 0 && idle_ticks != TIMER_MAX)
                    idle_ticks = idle_ticks + 1'b1;
                if (idle_ticks > lim)
                begin
                    ok = (count != 0) && (lead == hdr) && (tail == 8'(8'd0 - run_sum));
                    if (ok)
                        for (int i = 0; i < NUM_VALUES; i++)
                            held[i] = {field_q[2*i], field_q[2*i+1]};
                    r.frame_ok      = ok;
                    r.frame_length  = count;
                    r.concentration = held[0];
                    r.flow          = held[1];
                    r.temperature   = held[2];
                    expected_frames.push_back(r);
                    idle_ticks = '0;
                    count      = '0;
                    run_sum    = '0;
                    tail       = '0;
                end
            end
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                         $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(logic ok, logic [55:0] data);
            result_t want;
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected result", {15'd0, ok}, 16'd0);
                return;
            end
            want = expected_frames.pop_front();
            if (ok !== want.frame_ok)
                report_mismatch("frame_ok", {15'd0, ok}, {15'd0, want.frame_ok});
            if (data[5:0] !== want.frame_length)
                report_mismatch("frame_length", {10'd0, data[5:0]}, {10'd0, want.frame_length});
            if (data[21:6] !== want.concentration)
                report_mismatch("concentration", data[21:6], want.concentration);
            if (data[37:22] !== want.flow)
                report_mismatch("flow", data[37:22], want.flow);
            if (data[53:38] !== want.temperature)
                report_mismatch("temperature", data[53:38], want.temperature);
            if (data[55:54] !== 2'b00)
                report_mismatch("tdata padding", {14'd0, data[55:54]}, 16'd0);
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] rx_byte
    logic        s_tuser   = 1'b0;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;            // [5:0] frame_length, [21:6] concentration,
                                     // [37:22] flow, [53:38] temperature
    logic        m_tuser;            // [0] frame_ok
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;

    frame_scoreboard sb = new();

    // Stimulus control, changed per phase
    int unsigned idle_limit_now = IDLE_LIMIT_RST;
    logic [7:0]  header_now     = HEADER_BYTE_RST;
    int          gap_max_now    = 2;
    int          stall_mode     = 1;
    int          burst_left     = 0;
    int          stall_phase    = 0;
    int          sent_items     = 0;
    logic [7:0]  frame_q [$];

    idle_timeout_frame_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // Receiver backpressure: always ready, random stalls, or a repeating
    // pattern of ready and stalled cycles, chosen per phase.
    always @(negedge clk)
    begin
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 99) >= 35);
            default: m_tready <= ((stall_phase % 7) < 4);
        endcase
        stall_phase <= stall_phase + 1;
    end

    // Result monitor: sample the handshake at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Drive one transaction; entered and left at a falling edge. The
    // sender runs in bursts with random gaps when gap_max_now is nonzero.
    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max_now > 0) ? $urandom_range(0, gap_max_now) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.rx_byte;
        s_tuser  <= it.cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.predict_item(it);
        sent_items++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_ticks(input int unsigned n);
        item_t it;
        it.cmd = CMD_TICK;
        repeat (n)
        begin
            // the byte field is unused on ticks; keep it toggling
            it.rx_byte = 8'($urandom);
            send_item(it);
        end
    endtask

    // Send frame_q as bytes, optionally with ticks between them that do not exceed the limit
    // (rarely enough to break the frame early), then close the frame with limit+1 ticks.
    task automatic send_frame(input int split_pct);
        item_t       it;
        int unsigned k;
        int          roll;
        it.cmd = CMD_BYTE;
        for (int i = 0; i < frame_q.size(); i++)
        begin
            roll = $urandom_range(0, 99);
            if (i > 0 && idle_limit_now != 0 && roll < split_pct)
            begin
                if ($urandom_range(0, 3) == 0 && idle_limit_now <= 20)
                    k = idle_limit_now;   // right at the limit: frame stays open
                else
                    k = $urandom_range(1, (idle_limit_now > 4) ? 4 : idle_limit_now);
                send_ticks(k);
            end
            else if (i > 0 && roll >= 98 && split_pct > 0 && idle_limit_now <= 20)
                send_ticks(idle_limit_now + 1);   // break the frame early
            it.rx_byte = frame_q[i];
            send_item(it);
        end
        send_ticks(idle_limit_now + 1);
    endtask

    // Drop valid and wait until every expected result has arrived, then
    // let the pipeline settle.
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left  = 0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // Write both registers on back-to-back cycles; block must be idle.
    task automatic configure(input logic [7:0] limit, input logic [7:0] header);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IDLE_LIMIT;
        cfg_data  <= limit;
        @(negedge clk);
        cfg_index <= REG_HEADER_BYTE;
        cfg_data  <= header;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(REG_IDLE_LIMIT, limit);
        sb.write_reg(REG_HEADER_BYTE, header);
        idle_limit_now = limit;
        header_now     = header;
        @(negedge clk);
    endtask

    // One random phase: mostly well-formed frames with random content,
    // some with a wrong header or checksum, plus loose noise transactions.
    task automatic run_phase(input logic [7:0] limit, input logic [7:0] header,
                             input int budget, input int max_frames, input bit long_first,
                             input int gap_max, input int stall);
        item_t      it;
        int         start;
        int         frames;
        int         n;
        int         last_idx;
        int         roll;
        bit         hdr_ok;
        bit         sum_ok;
        logic [7:0] b;
        logic [7:0] sum;
        drain();
        configure(limit, header);
        gap_max_now = gap_max;
        stall_mode  = stall;
        start  = sent_items;
        frames = 0;
        while (sent_items - start < budget && frames < max_frames)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                it.cmd     = cmd_t'($urandom_range(0, 1));
                it.rx_byte = 8'($urandom);
                send_item(it);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if ((long_first && frames == 0) || roll < 3)
                    n = $urandom_range(64, 70);   // runs past the top buffer slot
                else if (roll < 15)
                    n = $urandom_range(13, 40);
                else
                    n = $urandom_range(1, 12);
                hdr_ok = ($urandom_range(0, 9) != 0);
                sum_ok = ($urandom_range(0, 4) != 0);
                // checksum sits at the last slot that still advances the count
                last_idx = ((n < BUFFER_DEPTH - 1) ? n : BUFFER_DEPTH - 1) - 1;
                sum = 8'd0;
                frame_q.delete();
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom);
                    if (i == 0 && hdr_ok)
                        b = header_now;
                    if (i == last_idx && sum_ok)
                        b = 8'd0 - sum;
                    if (i < last_idx)
                        sum = sum + b;
                    frame_q.push_back(b);
                end
                send_frame(15);
                frames++;
            end
        end
    endtask

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("idle_timeout_frame_checker verification failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset register values: tick with no open frame, then a
        // minimal good frame closed by the sixth tick.
        send_ticks(1);
        frame_q = '{8'h16, 8'hEA};
        send_frame(0);

        // Zero idle limit, header 0xFF: full frame with all six field bytes
        // and extreme byte values.
        drain();
        configure(8'd0, 8'hFF);
        frame_q = '{8'hFF, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h00, 8'hFF, 8'hAB, 8'hCD, 8'h45};
        send_frame(0);
        // Short good frame: field bytes stay stale from the previous frame.
        frame_q = '{8'hFF, 8'h01};
        send_frame(0);
        // Single byte frame: checksum against an empty sum fails.
        frame_q = '{8'hFF};
        send_frame(0);

        // Random phases across the register range, idling styles varied.
        run_phase(8'd0,   8'h00,           90,     1000, 1'b1, 0, 0);
        run_phase(8'd1,   8'hFF,           90,     1000, 1'b0, 3, 1);
        run_phase(8'd3,   8'($urandom),    90,     1000, 1'b0, 8, 2);
        run_phase(8'd254, 8'($urandom),    100000, 2,    1'b0, 2, 1);
        run_phase(8'd5,   HEADER_BYTE_RST, 90,     1000, 1'b1, 4, 1);
        run_phase(8'd2,   8'($urandom),    90,     1000, 1'b0, 1, 2);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("idle_timeout_frame_checker verification clean");
        else
            $display("idle_timeout_frame_checker verification failed");
        $finish;
    end

endmodule
